// ===== design/pfds_pkg.sv =====
// Shared widths, register indexes and saturating helpers of the PID step unit.
`timescale 1ns / 1ps
`default_nettype none

package pfds_pkg;

    localparam int DATA_W = 32;
    localparam int NTS_W  = 17;
    localparam int IDX_W  = 3;
    localparam int WIDE_W = 66;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam logic [IDX_W-1:0] REG_KP      = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI_TS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD_N    = 3'd2;
    localparam logic [IDX_W-1:0] REG_N_TS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_INT_MIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_INT_MAX = 3'd5;
    localparam logic [IDX_W-1:0] REG_OUT_MIN = 3'd6;
    localparam logic [IDX_W-1:0] REG_OUT_MAX = 3'd7;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    // Saturate a wide signed value to one word.
    function automatic word_t sat_word(input wide_t v);
        word_t r;
        if (v > wide_t'(WORD_MAX))
            r = WORD_MAX;
        else if (v < wide_t'(WORD_MIN))
            r = WORD_MIN;
        else
            r = word_t'(v);
        return r;
    endfunction

    // Upper limit first, then lower.
    function automatic word_t clamp_hi_lo(input wide_t v, input word_t lo, input word_t hi);
        word_t r;
        if (v > wide_t'(hi))
            r = hi;
        else if (v < wide_t'(lo))
            r = lo;
        else
            r = word_t'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/pfds_if.sv =====
// Valid/ready channel interfaces for error samples and drive results.
`timescale 1ns / 1ps
`default_nettype none

interface pfds_in_if;
    logic                  valid;
    logic                  ready;
    pfds_pkg::word_t       error;
    logic                  clear;

    modport source (output valid, output error, output clear, input ready);
    modport sink   (input valid, input error, input clear, output ready);
endinterface

interface pfds_out_if;
    logic                  valid;
    logic                  ready;
    pfds_pkg::word_t       drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ===== design/pid_filtered_derivative_step_unit.sv =====
// PID step with integral separation and filtered derivative, one shared multiplier.
// A sample steps through MP, MI, MD, DT, MN and SU to ST_OUT (a clear goes straight
// there) and waits while the output register is occupied. A new item is taken
// only in idle; one shared multiplier serves kp, ki_ts, kd_n, n_ts in sequence.
// Reset: rst_n asynchronous low; accumulators zero, gains zero, limits fully open.
`timescale 1ns / 1ps
`default_nettype none

module pid_filtered_derivative_step_unit #(
    parameter longint I_BAND    = 2147483647,
    parameter int     FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pfds_in_if.sink                            in_ch,
    pfds_out_if.source                         out_ch,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pfds_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [pfds_pkg::DATA_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MP   = 3'd1;
    localparam logic [2:0] ST_MI   = 3'd2;
    localparam logic [2:0] ST_MD   = 3'd3;
    localparam logic [2:0] ST_DT   = 3'd4;
    localparam logic [2:0] ST_MN   = 3'd5;
    localparam logic [2:0] ST_SU   = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam logic [32:0] BAND = 33'(I_BAND);

    logic [2:0] state_reg, state_next;

    pfds_pkg::word_t kp_reg, ki_ts_reg, kd_n_reg;
    logic [pfds_pkg::NTS_W-1:0] n_ts_reg;
    pfds_pkg::word_t int_min_reg, int_max_reg, out_min_reg, out_max_reg;

    pfds_pkg::word_t i_reg, i_next;
    pfds_pkg::word_t s_reg, s_next;

    pfds_pkg::word_t e_reg, p_reg, d_reg, prod_reg, drive_reg;
    logic            band_reg, clr_reg, out_valid_reg;
    logic signed [33:0] sum_reg;

    logic signed [32:0] mul_a, mul_b;
    pfds_pkg::wide_t    mul_prod, mul_shr;
    pfds_pkg::word_t    mul_sat;
    pfds_pkg::word_t    i_add;

    logic        in_xfer, out_xfer, out_load;
    logic [32:0] in_mag;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_xfer     = out_valid_reg && out_ch.ready;
    assign out_load     = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.drive = drive_reg;

    // Exact magnitude, 2^31 fits in 33 bits.
    assign in_mag = in_ch.error[31] ? (33'd0 - 33'(in_ch.error)) : 33'(in_ch.error);

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_MP:
            begin
                mul_a = 33'(kp_reg);
                mul_b = 33'(e_reg);
            end
            ST_MI:
            begin
                mul_a = 33'(ki_ts_reg);
                mul_b = 33'(e_reg);
            end
            ST_MD:
            begin
                mul_a = 33'(kd_n_reg);
                mul_b = 33'(e_reg);
            end
            ST_MN:
            begin
                mul_a = 33'(d_reg);
                mul_b = $signed({16'd0, n_ts_reg});
            end
            default:
            begin
                mul_a = 33'(kp_reg);
                mul_b = 33'(e_reg);
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign mul_shr  = mul_prod >>> FRAC_BITS;
    assign mul_sat  = pfds_pkg::sat_word(mul_shr);

    assign i_add = pfds_pkg::sat_word(pfds_pkg::wide_t'(i_reg) + pfds_pkg::wide_t'(prod_reg));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        s_next     = s_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_ch.clear)
                    begin
                        i_next     = '0;
                        s_next     = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MP;
                    end
                end
            end
            ST_MP: state_next = ST_MI;
            ST_MI: state_next = ST_MD;
            ST_MD:
            begin
                if (band_reg)
                    i_next = pfds_pkg::clamp_hi_lo(pfds_pkg::wide_t'(i_add),
                                                   int_min_reg, int_max_reg);
                else
                    i_next = '0;
                state_next = ST_DT;
            end
            ST_DT: state_next = ST_MN;
            ST_MN: state_next = ST_SU;
            ST_SU:
            begin
                s_next = pfds_pkg::clamp_hi_lo(
                    pfds_pkg::wide_t'(pfds_pkg::sat_word(
                        pfds_pkg::wide_t'(s_reg) + pfds_pkg::wide_t'(prod_reg))),
                    out_min_reg, out_max_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_ts_reg     <= '0;
            kd_n_reg      <= '0;
            n_ts_reg      <= '0;
            int_min_reg   <= pfds_pkg::WORD_MIN;
            int_max_reg   <= pfds_pkg::WORD_MAX;
            out_min_reg   <= pfds_pkg::WORD_MIN;
            out_max_reg   <= pfds_pkg::WORD_MAX;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            s_reg     <= s_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    pfds_pkg::REG_KP:      kp_reg      <= cfg_data;
                    pfds_pkg::REG_KI_TS:   ki_ts_reg   <= cfg_data;
                    pfds_pkg::REG_KD_N:    kd_n_reg    <= cfg_data;
                    pfds_pkg::REG_N_TS:    n_ts_reg    <= cfg_data[pfds_pkg::NTS_W-1:0];
                    pfds_pkg::REG_INT_MIN: int_min_reg <= cfg_data;
                    pfds_pkg::REG_INT_MAX: int_max_reg <= cfg_data;
                    pfds_pkg::REG_OUT_MIN: out_min_reg <= cfg_data;
                    pfds_pkg::REG_OUT_MAX: out_max_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_sat;
        if (in_xfer)
        begin
            e_reg    <= in_ch.error;
            band_reg <= (in_mag < BAND);
            clr_reg  <= in_ch.clear;
        end
        if (state_reg == ST_MI)
            p_reg <= prod_reg;
        if (state_reg == ST_DT)
            d_reg <= pfds_pkg::sat_word(pfds_pkg::wide_t'(prod_reg) - pfds_pkg::wide_t'(s_reg));
        if (state_reg == ST_SU)
            sum_reg <= 34'(p_reg) + 34'(i_reg) + 34'(d_reg);
        if (out_load)
            drive_reg <= clr_reg ? '0
                       : pfds_pkg::clamp_hi_lo(pfds_pkg::wide_t'(sum_reg),
                                               out_min_reg, out_max_reg);
    end

    a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_MP || state_reg == ST_OUT))
        else $error("transfer did not start a step or a clear");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("output valid raised outside the output step");

    a_s_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SU && out_min_reg <= out_max_reg)
        |=> (s_reg >= $past(out_min_reg) && s_reg <= $past(out_max_reg)))
        else $error("derivative state outside output limits");

    a_i_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MD && band_reg && int_min_reg <= int_max_reg)
        |=> (i_reg >= $past(int_min_reg) && i_reg <= $past(int_max_reg)))
        else $error("integral outside its limits");

endmodule

`default_nettype wire

// ===== dv/tb_pid_filtered_derivative_step_unit.sv =====
// Self-checking testbench for the PID step unit: directed corner cases, then random samples.
`timescale 1ns / 1ps

module tb_pid_filtered_derivative_step_unit;

    localparam longint BAND_LIMIT  = 2147483647;
    localparam int     FRAC        = 16;
    localparam int     CYCLE_LIMIT = 200000;
    localparam longint W_HI        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint W_LO        = -64'sh0000_0000_8000_0000;
    localparam pfds_pkg::word_t ONE = 32'sh0001_0000;

    typedef struct packed {
        pfds_pkg::word_t                kp;
        pfds_pkg::word_t                ki_ts;
        pfds_pkg::word_t                kd_n;
        logic [pfds_pkg::NTS_W-1:0]     n_ts;
        pfds_pkg::word_t                int_min;
        pfds_pkg::word_t                int_max;
        pfds_pkg::word_t                out_min;
        pfds_pkg::word_t                out_max;
    } tuning_t;

    // Predicts drive values and holds the ones still owed by the block.
    class drive_tracker;
        longint kp, ki_ts, kd_n, n_ts, int_min, int_max, out_min, out_max;
        longint integ, dstate;
        pfds_pkg::word_t expected_drive[$];
        int     n_samples, n_clears, n_checked, n_fail;

        function new();
            kp = 0;
            ki_ts = 0;
            kd_n = 0;
            n_ts = 0;
            int_min = W_LO;
            int_max = W_HI;
            out_min = W_LO;
            out_max = W_HI;
            integ = 0;
            dstate = 0;
            n_samples = 0;
            n_clears = 0;
            n_checked = 0;
            n_fail = 0;
        endfunction

        static function longint sat_w(longint v);
            if (v > W_HI)
                return W_HI;
            if (v < W_LO)
                return W_LO;
            return v;
        endfunction

        // Exact product, floor shift, saturate.
        static function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return sat_w(p >>> FRAC);
        endfunction

        // Upper limit wins when the limits cross.
        static function longint clamp_ul(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function void set_reg(logic [pfds_pkg::IDX_W-1:0] idx,
                              logic [pfds_pkg::DATA_W-1:0] val);
            pfds_pkg::word_t w;
            w = val;
            case (idx)
                pfds_pkg::REG_KP:      kp = w;
                pfds_pkg::REG_KI_TS:   ki_ts = w;
                pfds_pkg::REG_KD_N:    kd_n = w;
                pfds_pkg::REG_N_TS:    n_ts = longint'(val[pfds_pkg::NTS_W-1:0]);
                pfds_pkg::REG_INT_MIN: int_min = w;
                pfds_pkg::REG_INT_MAX: int_max = w;
                pfds_pkg::REG_OUT_MIN: out_min = w;
                pfds_pkg::REG_OUT_MAX: out_max = w;
                default: ;
            endcase
        endfunction

        function void note_sample(pfds_pkg::word_t err, bit clr);
            longint e, p, mag, d, sum;
            n_samples++;
            if (clr)
            begin
                n_clears++;
                integ = 0;
                dstate = 0;
                expected_drive.push_back('0);
                return;
            end
            e = err;
            p = qmul(kp, e);
            mag = (e < 0) ? -e : e;
            if (mag < BAND_LIMIT)
                integ = clamp_ul(sat_w(integ + qmul(ki_ts, e)), int_min, int_max);
            else
                integ = 0;
            d = sat_w(qmul(kd_n, e) - dstate);
            dstate = clamp_ul(sat_w(dstate + qmul(d, n_ts)), out_min, out_max);
            sum = clamp_ul(p + integ + d, out_min, out_max);
            expected_drive.push_back(pfds_pkg::word_t'(sum));
        endfunction

        function void check_drive(pfds_pkg::word_t got);
            pfds_pkg::word_t want;
            if (expected_drive.size() == 0)
            begin
                n_fail++;
                $error("drive: expected nothing, got %0d", got);
                return;
            end
            want = expected_drive.pop_front();
            n_checked++;
            if (got !== want)
            begin
                n_fail++;
                $error("drive: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [pfds_pkg::IDX_W-1:0]     cfg_index;
    logic [pfds_pkg::DATA_W-1:0]    cfg_data;
    int                             tx_idle_pct = 0;
    int                             rx_idle_pct = 0;
    int                             n_settings = 0;
    pfds_pkg::word_t                last_err;
    drive_tracker                   tracker = new();

    pfds_in_if  in_ch();
    pfds_out_if out_ch();

    pid_filtered_derivative_step_unit #(
        .I_BAND    (BAND_LIMIT),
        .FRAC_BITS (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic tuning_t make_tuning(pfds_pkg::word_t kp, pfds_pkg::word_t ki,
                                            pfds_pkg::word_t kd,
                                            logic [pfds_pkg::NTS_W-1:0] nts,
                                            pfds_pkg::word_t imin, pfds_pkg::word_t imax,
                                            pfds_pkg::word_t omin, pfds_pkg::word_t omax);
        tuning_t t;
        t.kp = kp;
        t.ki_ts = ki;
        t.kd_n = kd;
        t.n_ts = nts;
        t.int_min = imin;
        t.int_max = imax;
        t.out_min = omin;
        t.out_max = omax;
        return t;
    endfunction

    function automatic pfds_pkg::word_t pick_gain();
        pfds_pkg::word_t r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r = $urandom_range(0, 524288) - 262144;
            6, 7:             r = $urandom;
            8:                r = $urandom_range(0, 1) ? pfds_pkg::WORD_MAX : pfds_pkg::WORD_MIN;
            default:          r = '0;
        endcase
        return r;
    endfunction

    function automatic void pick_limits(output pfds_pkg::word_t lo,
                                        output pfds_pkg::word_t hi);
        pfds_pkg::word_t a, b;
        a = $urandom_range(0, 33554432) - 16777216;
        b = $urandom_range(0, 33554432) - 16777216;
        case ($urandom_range(0, 5))
            0:
            begin
                lo = pfds_pkg::WORD_MIN;
                hi = pfds_pkg::WORD_MAX;
            end
            4:
            begin
                // crossed limits
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            5:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            default:
            begin
                lo = (a > b) ? b : a;
                hi = (a > b) ? a : b;
            end
        endcase
    endfunction

    function automatic tuning_t pick_tuning();
        tuning_t                        t;
        logic [pfds_pkg::NTS_W-1:0]     nts;
        pfds_pkg::word_t                lo, hi;
        case ($urandom_range(0, 7))
            0:       nts = 17'($urandom_range(65537, 131071));
            1:       nts = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
            default: nts = 17'($urandom_range(0, 65536));
        endcase
        t = make_tuning(pick_gain(), pick_gain(), pick_gain(), nts, '0, '0, '0, '0);
        pick_limits(lo, hi);
        t.int_min = lo;
        t.int_max = hi;
        pick_limits(lo, hi);
        t.out_min = lo;
        t.out_max = hi;
        return t;
    endfunction

    function automatic pfds_pkg::word_t pick_error();
        pfds_pkg::word_t r;
        case ($urandom_range(0, 9))
            0, 1, 2: r = $urandom_range(0, 2097152) - 1048576;
            3, 4:    r = last_err + ($urandom_range(0, 8192) - 4096);
            5, 6:    r = $urandom;
            7:       r = $urandom_range(0, 268435456) - 134217728;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       r = pfds_pkg::WORD_MAX;
                    1:       r = pfds_pkg::WORD_MIN;
                    2:       r = pfds_pkg::WORD_MAX - 1;
                    3:       r = -pfds_pkg::WORD_MAX;
                    4:       r = '0;
                    default: r = -(pfds_pkg::WORD_MAX - 1);
                endcase
            end
        endcase
        return r;
    endfunction

    task automatic write_reg(input logic [pfds_pkg::IDX_W-1:0] idx,
                             input logic [pfds_pkg::DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_tuning(input tuning_t t);
        write_reg(pfds_pkg::REG_KP, t.kp);
        write_reg(pfds_pkg::REG_KI_TS, t.ki_ts);
        write_reg(pfds_pkg::REG_KD_N, t.kd_n);
        write_reg(pfds_pkg::REG_N_TS, {{(pfds_pkg::DATA_W-pfds_pkg::NTS_W){1'b0}}, t.n_ts});
        write_reg(pfds_pkg::REG_INT_MIN, t.int_min);
        write_reg(pfds_pkg::REG_INT_MAX, t.int_max);
        write_reg(pfds_pkg::REG_OUT_MIN, t.out_min);
        write_reg(pfds_pkg::REG_OUT_MAX, t.out_max);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic send_sample(input pfds_pkg::word_t err, input bit clr);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.error <= err;
        in_ch.clear <= clr;
        do
            @(posedge clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        tracker.note_sample(err, clr);
        last_err = err;
    endtask

    // Drop valid and hold until every owed drive value has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.expected_drive.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_sample(pick_error(), $urandom_range(0, 99) < 3);
    endtask

    // Result side: check each transfer, then pick the next ready.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                tracker.check_drive(out_ch.drive);
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_pid_filtered_derivative_step_unit NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.error = '0;
        in_ch.clear = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        last_err = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gains: every term is zero.
        rx_idle_pct = 30;
        send_sample(ONE, 1'b0);

        drain();
        apply_tuning(make_tuning(ONE, 32'sh0000_8000, 32'sh0002_0000, 17'h04000,
                                 pfds_pkg::WORD_MIN, pfds_pkg::WORD_MAX,
                                 pfds_pkg::WORD_MIN, pfds_pkg::WORD_MAX));
        send_sample('0, 1'b0);
        send_sample(ONE, 1'b0);
        send_sample(-ONE, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(-32'sd1, 1'b0);
        // band edges: full scale drops the integral, one step inside keeps it
        send_sample(pfds_pkg::WORD_MAX, 1'b0);
        send_sample(pfds_pkg::WORD_MIN, 1'b0);
        send_sample(pfds_pkg::WORD_MAX - 1, 1'b0);
        send_sample(-pfds_pkg::WORD_MAX, 1'b0);
        send_sample(-(pfds_pkg::WORD_MAX - 1), 1'b0);
        send_sample(5 * ONE, 1'b1);
        send_sample(3 * ONE, 1'b0);
        send_sample(3 * ONE, 1'b0);

        // Full-scale gains, filter coefficient above 1.0, crossed limits.
        drain();
        apply_tuning(make_tuning(pfds_pkg::WORD_MAX, pfds_pkg::WORD_MIN,
                                 pfds_pkg::WORD_MAX, 17'h1FFFF,
                                 100 * ONE, -100 * ONE, 50 * ONE, -50 * ONE));
        send_sample(pfds_pkg::WORD_MAX, 1'b0);
        send_sample(pfds_pkg::WORD_MIN, 1'b0);
        send_sample(ONE, 1'b0);
        send_sample(-ONE, 1'b0);
        send_sample('0, 1'b0);
        send_sample(ONE, 1'b1);
        send_sample(32'sd2, 1'b0);

        // Full-scale gains, kp and kd negative, with tight limits.
        drain();
        apply_tuning(make_tuning(pfds_pkg::WORD_MIN, pfds_pkg::WORD_MAX,
                                 pfds_pkg::WORD_MIN, 17'h10000,
                                 -ONE, ONE, -10 * ONE, 10 * ONE));
        send_sample(ONE / 2, 1'b0);
        send_sample(ONE / 2, 1'b0);
        send_sample(-2 * ONE, 1'b0);
        send_sample(pfds_pkg::WORD_MIN, 1'b0);
        send_sample(pfds_pkg::WORD_MAX, 1'b0);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 55;
                end
                1:
                begin
                    tx_idle_pct = 55;
                    rx_idle_pct = 9;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (2)
            begin
                drain();
                apply_tuning(pick_tuning());
                run_random(65);
            end
        end

        drain();
        repeat (16) @(posedge clk);

        $display("%0d drive values checked from %0d error samples, %0d of them clears",
                 tracker.n_checked, tracker.n_samples, tracker.n_clears);
        $display("%0d register settings used, full-scale gains and crossed limits included",
                 n_settings);
        if (tracker.n_fail == 0)
            $display("tb_pid_filtered_derivative_step_unit OK");
        else
            $display("tb_pid_filtered_derivative_step_unit NOT OK");
        $finish;
    end

endmodule
